FILE: rtl/used_block_bitmap_scanner_macros.svh
// Assertion macros shared by the used-block bitmap scanner RTL.
`ifndef USED_BLOCK_BITMAP_SCANNER_MACROS_SVH
`define USED_BLOCK_BITMAP_SCANNER_MACROS_SVH

// Plain check on every clock edge outside reset.
`define UBBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication outside reset.
`define UBBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ubbs_pkg.sv
// Shared types, codes, widths and helper functions of the used-block bitmap scanner.
package ubbs_pkg;

    localparam int OP_W         = 2;
    localparam int OFF_W        = 32;
    localparam int IDX_W        = 12;
    localparam int ST_W         = 2;
    localparam int BS_W         = 21;
    localparam int BC_W         = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 21;

    localparam int MAX_BLOCKS_DEF   = 4096;
    localparam int WORD_W           = 32;
    localparam int WORD_BIT_W       = $clog2(WORD_W);
    localparam int BITMAP_WORDS_DEF = (MAX_BLOCKS_DEF + WORD_W - 1) / WORD_W;

    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = OFF_W / DIV_BITS;

    localparam logic [OP_W-1:0] OP_MARK      = 2'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE   = 2'd1;
    localparam logic [OP_W-1:0] OP_NEW_IMAGE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    localparam logic [BS_W-1:0] BS_RESET = 21'd512;
    localparam logic [BC_W-1:0] BC_RESET = 13'd4096;

    function automatic logic [WORD_BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [WORD_BIT_W-1:0] p;
        p = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                p = WORD_BIT_W'(i);
            end
        end
        return p;
    endfunction

endpackage

FILE: rtl/ubbs_bitmap_ram.sv
// Word-wide used-block bitmap memory, one write port and one registered read port.
module ubbs_bitmap_ram #(
    parameter int DEPTH  = ubbs_pkg::BITMAP_WORDS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [ubbs_pkg::WORD_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic [ubbs_pkg::WORD_W-1:0] o_rd_data
);
    import ubbs_pkg::*;

    logic [WORD_W-1:0] r_mem [0:DEPTH-1];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/ubbs_divider.sv
// Iterative restoring divider turning a byte offset into a block index, two bits per cycle.
module ubbs_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ubbs_pkg::OFF_W-1:0] i_dividend,
    input  logic [ubbs_pkg::BS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [ubbs_pkg::OFF_W-1:0] o_quotient
);
    import ubbs_pkg::*;

    localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [BS_W-1:0]  r_rem;
    logic [BS_W-1:0]  n_rem;
    logic [OFF_W-1:0] r_q;
    logic [OFF_W-1:0] n_q;
    logic [BS_W-1:0]  r_d;

    always_comb begin
        logic [BS_W:0] t;
        t     = '0;
        n_rem = r_rem;
        n_q   = r_q;
        for (int k = 0; k < DIV_BITS; k++) begin
            t   = {n_rem, n_q[OFF_W-1]};
            n_q = {n_q[OFF_W-2:0], 1'b0};
            if (t >= {1'b0, r_d}) begin
                t      = t - {1'b0, r_d};
                n_q[0] = 1'b1;
            end
            n_rem = t[BS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

FILE: rtl/used_block_bitmap_scanner.sv
// Top level of the used-block bitmap scanner: control sequencer, config registers, output stage.
//
// Input channel (i_in_valid / o_in_stall) takes one request: mark an offset's block used,
// advance the cursor to the next unused block, or start a new image at an offset.
// Every request yields one result (o_out_valid / i_out_stall): cursor and status.
// Config writes (i_cfg_valid / o_cfg_ready, ready always high) set block size and count.
// Mark and new image run a 2-bit-per-cycle divider.
// Advance reads, sets and writes back the cursor's bitmap word, then walks the bitmap one
// 32-bit word at a time, each word read in S_SRD and then evaluated in S_SEV.
// The registered read of the bitmap memory, read then evaluate, sets the scan speed.
// Code 3 returns the cursor with status ok.
// One request is in flight at a time; o_in_stall is high while it is worked on.
// After reset the bitmap is cleared one word per cycle, with o_in_stall high;
// config writes are taken meanwhile.
// A stalled result holds in the output register; the next request can be accepted, and
// its result waits until the output register is free.
`include "used_block_bitmap_scanner_macros.svh"

module used_block_bitmap_scanner #(
    parameter int MAX_BLOCKS = ubbs_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ubbs_pkg::OP_W-1:0]       i_operation,
    input  logic [ubbs_pkg::OFF_W-1:0]      i_offset,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ubbs_pkg::IDX_W-1:0]      o_current_index,
    output logic [ubbs_pkg::ST_W-1:0]       o_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ubbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ubbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ubbs_pkg::*;

    localparam int CW     = $clog2(MAX_BLOCKS);
    localparam int NW     = $clog2(MAX_BLOCKS + 1);
    localparam int NWORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int IW     = AW + WORD_BIT_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MWR   = 3'd3;
    localparam logic [2:0] S_ASET  = 3'd4;
    localparam logic [2:0] S_SRD   = 3'd5;
    localparam logic [2:0] S_SEV   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]            r_state,       n_state;
    logic [AW-1:0]         r_clr_addr,    n_clr_addr;
    logic [CW-1:0]         r_cursor,      n_cursor;
    logic [CW-1:0]         r_scan_start,  n_scan_start;
    logic                  r_out_valid,   n_out_valid;
    logic [IDX_W-1:0]      r_out_idx,     n_out_idx;
    logic [ST_W-1:0]       r_out_status,  n_out_status;
    logic [OP_W-1:0]       r_op,          n_op;
    logic [AW-1:0]         r_waddr,       n_waddr;
    logic [WORD_BIT_W-1:0] r_tbit,        n_tbit;
    logic                  r_first,       n_first;
    logic                  r_last,        n_last;
    logic [ST_W-1:0]       r_res_status,  n_res_status;
    logic [BS_W-1:0]       r_block_size;
    logic [BC_W-1:0]       r_block_count;

    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [WORD_W-1:0]     ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [WORD_W-1:0]     ram_rd_data;

    logic                  div_start;
    logic                  div_done;
    logic [OFF_W-1:0]      div_q;
    logic [BS_W-1:0]       div_d;

    logic [NW-1:0]         eff_n;
    logic [IW-1:0]         nl_ext;
    logic [AW-1:0]         wl;
    logic [WORD_BIT_W-1:0] lb;
    logic [CW-1:0]         adv_c;
    logic [IW-1:0]         adv_ext;
    logic [IW-1:0]         ss_ext;
    logic [AW-1:0]         sw;
    logic [WORD_BIT_W-1:0] sb;
    logic [IW-1:0]         q_ext;
    logic                  q_ok;
    logic [WORD_W-1:0]     mask_v;
    logic [WORD_W-1:0]     mask_p;
    logic [WORD_W-1:0]     cand;
    logic                  hit;
    logic [CW-1:0]         found;
    logic [AW-1:0]         w_next;
    logic                  acc;

    ubbs_bitmap_ram #(
        .DEPTH  (NWORDS),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    ubbs_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_offset),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign div_d = (r_block_size == '0) ? BS_W'(1) : r_block_size;

    always_comb begin
        if (r_block_count == '0) begin
            eff_n = NW'(1);
        end else if (32'(r_block_count) > 32'(MAX_BLOCKS)) begin
            eff_n = NW'(MAX_BLOCKS);
        end else begin
            eff_n = NW'(r_block_count);
        end
    end

    assign nl_ext  = IW'(eff_n - NW'(1));
    assign wl      = nl_ext[IW-1:WORD_BIT_W];
    assign lb      = nl_ext[WORD_BIT_W-1:0];
    assign adv_c   = (NW'(r_cursor) >= eff_n) ? '0 : r_cursor;
    assign adv_ext = IW'(adv_c);
    assign ss_ext  = IW'(r_scan_start);
    assign sw      = ss_ext[IW-1:WORD_BIT_W];
    assign sb      = ss_ext[WORD_BIT_W-1:0];
    assign q_ext   = IW'(div_q);
    assign q_ok    = div_q < OFF_W'(eff_n);

    assign mask_v = (r_waddr == wl) ?
                    ({WORD_W{1'b1}} >> (WORD_BIT_W'(WORD_W - 1) - lb)) : {WORD_W{1'b1}};
    assign mask_p = r_first ? (({WORD_W{1'b1}} << sb) << 1) :
                    r_last  ? ~({WORD_W{1'b1}} << sb) : {WORD_W{1'b1}};
    assign cand   = ~ram_rd_data & mask_v & mask_p;
    assign hit    = |cand;
    assign found  = CW'({r_waddr, lowest_set(cand)});
    assign w_next = (r_waddr == wl) ? '0 : r_waddr + AW'(1);

    assign acc        = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_cursor     = r_cursor;
        n_scan_start = r_scan_start;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_idx    = r_out_idx;
        n_out_status = r_out_status;
        n_op         = r_op;
        n_waddr      = r_waddr;
        n_tbit       = r_tbit;
        n_first      = r_first;
        n_last       = r_last;
        n_res_status = r_res_status;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_waddr;
        ram_wr_data  = '0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_waddr;
        div_start    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                n_clr_addr  = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(NWORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_op = i_operation;
                    case (i_operation)
                        OP_MARK, OP_NEW_IMAGE: begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                        OP_ADVANCE: begin
                            n_scan_start = adv_c;
                            ram_rd_en    = 1'b1;
                            ram_rd_addr  = adv_ext[IW-1:WORD_BIT_W];
                            n_waddr      = adv_ext[IW-1:WORD_BIT_W];
                            n_first      = 1'b1;
                            n_last       = 1'b0;
                            n_state      = S_ASET;
                        end
                        default: begin
                            n_res_status = ST_OK;
                            n_state      = S_OUT;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (!q_ok) begin
                        n_res_status = ST_RANGE;
                        n_state      = S_OUT;
                    end else if (r_op == OP_MARK) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = q_ext[IW-1:WORD_BIT_W];
                        n_waddr     = q_ext[IW-1:WORD_BIT_W];
                        n_tbit      = q_ext[WORD_BIT_W-1:0];
                        n_state     = S_MWR;
                    end else begin
                        n_cursor     = CW'(div_q);
                        n_scan_start = CW'(div_q);
                        n_res_status = ST_OK;
                        n_state      = S_OUT;
                    end
                end
            end
            S_MWR: begin
                ram_wr_en    = 1'b1;
                ram_wr_data  = ram_rd_data | (WORD_W'(1) << r_tbit);
                n_res_status = ST_OK;
                n_state      = S_OUT;
            end
            S_ASET: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data | (WORD_W'(1) << sb);
                n_first     = 1'b0;
                if (hit) begin
                    n_cursor     = found;
                    n_res_status = ST_OK;
                    n_state      = S_OUT;
                end else begin
                    n_waddr = w_next;
                    n_last  = (w_next == sw);
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                ram_rd_en = 1'b1;
                n_state   = S_SEV;
            end
            S_SEV: begin
                if (hit) begin
                    n_cursor     = found;
                    n_res_status = ST_OK;
                    n_state      = S_OUT;
                end else if (r_last) begin
                    n_cursor     = r_scan_start;
                    n_res_status = ST_EXHAUSTED;
                    n_state      = S_OUT;
                end else begin
                    n_waddr = w_next;
                    n_last  = (w_next == sw);
                    n_state = S_SRD;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = IDX_W'(r_cursor);
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_cursor     <= '0;
            r_scan_start <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_cursor     <= n_cursor;
            r_scan_start <= n_scan_start;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_idx    <= n_out_idx;
        r_out_status <= n_out_status;
        r_op         <= n_op;
        r_waddr      <= n_waddr;
        r_tbit       <= n_tbit;
        r_first      <= n_first;
        r_last       <= n_last;
        r_res_status <= n_res_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= BS_RESET;
            r_block_count <= BC_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BLOCK_SIZE:  r_block_size  <= i_cfg_data[BS_W-1:0];
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[BC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_current_index = r_out_idx;
    assign o_status        = r_out_status;

    `UBBS_ASSERT_IMP(a_clear_no_out, r_state == S_CLEAR, !o_out_valid, "result during bitmap clear")
    `UBBS_ASSERT(a_ram_one_access, !(ram_wr_en && ram_rd_en), "bitmap read and write together")
    `UBBS_ASSERT_IMP(a_div_done_waits, div_done, r_state == S_DIV, "divider done outside wait")
    `UBBS_ASSERT_IMP(a_scan_in_range, r_state == S_SEV, r_waddr <= wl, "scan word past block count")
    `UBBS_ASSERT_IMP(a_out_from_done, $rose(o_out_valid), $past(r_state) == S_OUT, "stray result")

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the used-block bitmap scanner: directed table, then random traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ubbs_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam logic [BS_W-1:0] BS_MAX = 21'h1F_FFFF;
    localparam int RANDOM_REQUESTS = 1200;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef enum logic { ROW_REQ, ROW_CFG } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [OP_W-1:0]        op;
        logic [OFF_W-1:0]       value;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic                   typed;
        logic [IDX_W-1:0]       exp_idx;
        logic [ST_W-1:0]        exp_st;
    } t_stim_row;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [ST_W-1:0]  st;
    } t_scan_result;

    localparam t_stim_row DIRECTED_ROWS [28] = '{
        '{ROW_REQ, OP_RESERVED,  32'h0000_0000, CFG_BLOCK_SIZE,  1'b1, 12'd0,    ST_OK},
        '{ROW_REQ, OP_ADVANCE,   32'h0000_0000, CFG_BLOCK_SIZE,  1'b1, 12'd1,    ST_OK},
        '{ROW_REQ, OP_MARK,      32'h0000_0000, CFG_BLOCK_SIZE,  1'b1, 12'd1,    ST_OK},
        '{ROW_REQ, OP_MARK,      32'hFFFF_FFFF, CFG_BLOCK_SIZE,  1'b1, 12'd1,    ST_RANGE},
        '{ROW_REQ, OP_MARK,      32'd2097151,   CFG_BLOCK_SIZE,  1'b1, 12'd1,    ST_OK},
        '{ROW_REQ, OP_MARK,      32'd2097152,   CFG_BLOCK_SIZE,  1'b1, 12'd1,    ST_RANGE},
        '{ROW_REQ, OP_NEW_IMAGE, 32'hFFFF_FFFF, CFG_BLOCK_SIZE,  1'b1, 12'd1,    ST_RANGE},
        '{ROW_REQ, OP_NEW_IMAGE, 32'd2097151,   CFG_BLOCK_SIZE,  1'b1, 12'd4095, ST_OK},
        '{ROW_REQ, OP_ADVANCE,   32'h0000_0000, CFG_BLOCK_SIZE,  1'b0, 12'd0,    ST_OK},
        '{ROW_REQ, OP_NEW_IMAGE, 32'd2560,      CFG_BLOCK_SIZE,  1'b1, 12'd5,    ST_OK},
        '{ROW_REQ, OP_RESERVED,  32'hFFFF_FFFF, CFG_BLOCK_SIZE,  1'b1, 12'd5,    ST_OK},
        '{ROW_REQ, OP_MARK,      32'd3072,      CFG_BLOCK_SIZE,  1'b1, 12'd5,    ST_OK},
        '{ROW_REQ, OP_ADVANCE,   32'hFFFF_FFFF, CFG_BLOCK_SIZE,  1'b0, 12'd0,    ST_OK},
        '{ROW_CFG, OP_MARK,      32'd0,         CFG_BLOCK_SIZE,  1'b0, 12'd0,    ST_OK},
        '{ROW_CFG, OP_MARK,      32'd0,         CFG_BLOCK_COUNT, 1'b0, 12'd0,    ST_OK},
        '{ROW_REQ, OP_ADVANCE,   32'h0000_0000, CFG_BLOCK_SIZE,  1'b1, 12'd0,    ST_EXHAUSTED},
        '{ROW_REQ, OP_MARK,      32'd1,         CFG_BLOCK_SIZE,  1'b1, 12'd0,    ST_RANGE},
        '{ROW_REQ, OP_NEW_IMAGE, 32'd0,         CFG_BLOCK_SIZE,  1'b1, 12'd0,    ST_OK},
        '{ROW_REQ, OP_MARK,      32'd0,         CFG_BLOCK_SIZE,  1'b1, 12'd0,    ST_OK},
        '{ROW_CFG, OP_MARK,      32'h001F_FFFF, CFG_BLOCK_SIZE,  1'b0, 12'd0,    ST_OK},
        '{ROW_CFG, OP_MARK,      32'h001F_FFFF, CFG_BLOCK_COUNT, 1'b0, 12'd0,    ST_OK},
        '{ROW_REQ, OP_MARK,      32'hFFFF_FFFF, CFG_BLOCK_SIZE,  1'b0, 12'd0,    ST_OK},
        '{ROW_REQ, OP_NEW_IMAGE, 32'hFFFF_FFFF, CFG_BLOCK_SIZE,  1'b0, 12'd0,    ST_OK},
        '{ROW_REQ, OP_ADVANCE,   32'h0000_0000, CFG_BLOCK_SIZE,  1'b0, 12'd0,    ST_OK},
        '{ROW_CFG, OP_MARK,      32'd1,         CFG_BLOCK_SIZE,  1'b0, 12'd0,    ST_OK},
        '{ROW_CFG, OP_MARK,      32'd3,         CFG_BLOCK_COUNT, 1'b0, 12'd0,    ST_OK},
        '{ROW_REQ, OP_ADVANCE,   32'h0000_0000, CFG_BLOCK_SIZE,  1'b0, 12'd0,    ST_OK},
        '{ROW_REQ, OP_ADVANCE,   32'hFFFF_FFFF, CFG_BLOCK_SIZE,  1'b0, 12'd0,    ST_OK}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic [OP_W-1:0]       in_operation = OP_MARK;
    logic [OFF_W-1:0]      in_offset = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_BLOCK_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [IDX_W-1:0]      o_current_index;
    logic [ST_W-1:0]       o_status;
    logic                  o_cfg_ready;

    bit           blk_taken [MAX_BLOCKS_DEF];
    int unsigned  cursor_blk = 0;
    int unsigned  scan_origin = 0;
    logic [BS_W-1:0] blk_size = BS_RESET;
    logic [BC_W-1:0] blk_count = BC_RESET;

    t_scan_result expected_scans [$];
    int  mismatches = 0;
    int  burst_left = 0;
    bit  hold_request = 1'b0;

    used_block_bitmap_scanner dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (in_operation),
        .i_offset        (in_offset),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_current_index (o_current_index),
        .o_status        (o_status),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned effective_count();
        if (blk_count == '0) begin
            return 1;
        end
        if (blk_count > MAX_BLOCKS_DEF) begin
            return MAX_BLOCKS_DEF;
        end
        return 32'(blk_count);
    endfunction

    function automatic void predict_scan(input logic [OP_W-1:0] op, input logic [OFF_W-1:0] off,
                                         output t_scan_result res);
        int unsigned n;
        int unsigned blk;
        logic [ST_W-1:0] st;
        n = effective_count();
        st = ST_OK;
        blk = off / ((blk_size == '0) ? 32'd1 : {11'd0, blk_size});
        case (op)
            OP_MARK: begin
                if (blk >= n) st = ST_RANGE;
                else blk_taken[blk] = 1'b1;
            end
            OP_ADVANCE: begin
                if (cursor_blk >= n) cursor_blk = 0;
                blk_taken[cursor_blk] = 1'b1;
                scan_origin = cursor_blk;
                while (blk_taken[cursor_blk] && st == ST_OK) begin
                    cursor_blk = (cursor_blk + 1) % n;
                    if (cursor_blk == scan_origin) st = ST_EXHAUSTED;
                end
            end
            OP_NEW_IMAGE: begin
                if (blk >= n) begin
                    st = ST_RANGE;
                end else begin
                    cursor_blk = blk;
                    scan_origin = blk;
                end
            end
            default: ;
        endcase
        res.idx = IDX_W'(cursor_blk);
        res.st = st;
    endfunction

    function automatic logic [OFF_W-1:0] pick_offset();
        int unsigned n;
        int unsigned bs;
        int unsigned blk;
        longint unsigned byte_pos;
        n = effective_count();
        bs = (blk_size == '0) ? 1 : 32'(blk_size);
        if ($urandom_range(0, 3) == 0) return $urandom;
        blk = ($urandom_range(0, 7) == 0) ? n + $urandom_range(0, 3) : $urandom_range(0, n - 1);
        byte_pos = longint'(blk) * bs + $urandom_range(0, bs - 1);
        if (byte_pos > 64'hFFFF_FFFF) return $urandom;
        return byte_pos[OFF_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_scans.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!o_cfg_ready);
        if (idx == CFG_BLOCK_SIZE) blk_size = data[BS_W-1:0];
        else blk_count = data[BC_W-1:0];
    endtask

    task automatic send_request(input logic [OP_W-1:0] op, input logic [OFF_W-1:0] off,
                                input logic typed, input logic [IDX_W-1:0] t_idx,
                                input logic [ST_W-1:0] t_st);
        int gap;
        t_scan_result res;
        if (cfg_valid) cfg_valid <= 1'b0;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        in_operation <= op;
        in_offset <= off;
        do @(posedge clk); while (o_in_stall);
        burst_left--;
        predict_scan(op, off, res);
        if (typed) res = '{t_idx, t_st};
        expected_scans.push_back(res);
    endtask

    always @(posedge clk) begin
        t_scan_result want;
        if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (expected_scans.size() == 0) begin
                report_mismatch($sformatf("result with no request pending: index %0d status %0d",
                                          o_current_index, o_status));
            end else begin
                want = expected_scans.pop_front();
                if (o_current_index !== want.idx) begin
                    report_mismatch($sformatf("current_index %0d, expected %0d",
                                              o_current_index, want.idx));
                end
                if (o_status !== want.st) begin
                    report_mismatch($sformatf("status %0d, expected %0d", o_status, want.st));
                end
            end
        end
    end

    initial begin : receiver
        int mode;
        int mode_left;
        int held;
        bit hold_done;
        mode = 0;
        mode_left = 0;
        held = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request && !hold_done) begin
                out_stall <= 1'b1;
                held++;
                if (held == HOLD_OFF_CYCLES) hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial begin : stimulus
        int sent;
        int phase_len;
        int pick;
        logic [OP_W-1:0] op;
        logic [BS_W-1:0] size_val;
        logic [BC_W-1:0] count_val;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
                write_reg(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].value[CFG_DATA_W-1:0]);
            end else begin
                send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed,
                             DIRECTED_ROWS[r].exp_idx, DIRECTED_ROWS[r].exp_st);
            end
        end

        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            case ($urandom_range(0, 7))
                0: size_val = '0;
                1: size_val = 21'd1;
                2, 3: size_val = BS_W'($urandom_range(2, 16));
                4, 5: size_val = BS_W'($urandom_range(17, 4096));
                6: size_val = BS_MAX;
                default: size_val = BS_W'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0: count_val = '0;
                1: count_val = 13'd1;
                2: count_val = 13'd2;
                3, 4: count_val = BC_W'($urandom_range(3, 64));
                5, 6: count_val = BC_W'($urandom_range(65, 1024));
                7: count_val = 13'd4096;
                8: count_val = BC_W'($urandom_range(1025, 4095));
                default: count_val = BC_W'($urandom_range(4097, 8191));
            endcase
            write_reg(CFG_BLOCK_SIZE, size_val);
            write_reg(CFG_BLOCK_COUNT, {8'($urandom_range(0, 255)), count_val});
            if (sent == 0) hold_request = 1'b1;
            phase_len = $urandom_range(40, 120);
            if (phase_len > RANDOM_REQUESTS - sent) phase_len = RANDOM_REQUESTS - sent;
            repeat (phase_len) begin
                pick = $urandom_range(0, 19);
                if (pick < 8) op = OP_MARK;
                else if (pick < 15) op = OP_ADVANCE;
                else if (pick < 19) op = OP_NEW_IMAGE;
                else op = OP_RESERVED;
                send_request(op, (op == OP_MARK || op == OP_NEW_IMAGE) ? pick_offset() : $urandom,
                             1'b0, '0, ST_OK);
                sent++;
            end
        end

        wait_idle();
        repeat (60) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS used_block_bitmap_scanner");
        end else begin
            $display("FAIL used_block_bitmap_scanner");
        end
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("FAIL used_block_bitmap_scanner");
        $finish;
    end

endmodule
